// File: hdl/irans_pkg.sv
// Package for the interleaved rANS encoder step.
// Types, command codes, register indexes and sizes; no dependencies.
package irans_pkg;

	localparam int LANES    = 64;
	localparam int ALPHABET = 256;
	localparam int LANE_W   = $clog2(LANES);
	localparam int SYM_W    = $clog2(ALPHABET);
	localparam int FREQ_W   = 16;
	localparam int CUM_W    = 15;
	localparam int STATE_W  = 32;
	localparam int PB_W     = 4;
	localparam int LB_W     = 17;
	localparam int WORD_W   = 16;
	localparam int CNT_W    = $clog2(STATE_W);

	localparam logic [STATE_W-1:0] LANE_RESET = 32'h0001_0000;
	localparam logic [PB_W-1:0]    PB_RESET   = 4'd15;
	localparam logic [LB_W-1:0]    LB_RESET   = 17'h1_0000;

	typedef enum logic [1:0] {
		CMD_LOAD   = 2'd0,
		CMD_ENCODE = 2'd1,
		CMD_READ   = 2'd2,
		CMD_INIT   = 2'd3
	} cmd_t;

	typedef enum logic {
		CFG_PROB_BITS   = 1'b0,
		CFG_LOWER_BOUND = 1'b1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_CMP,
		S_DIV,
		S_DONE
	} fsm_t;

	typedef struct packed {
		cmd_t               cmd;
		logic [LANE_W-1:0]  lane;
		logic [SYM_W-1:0]   symbol;
		logic [FREQ_W-1:0]  freq_in;
		logic [CUM_W-1:0]   cumul_in;
	} item_t;

	typedef struct packed {
		logic               word_valid;
		logic [WORD_W-1:0]  word_out;
		logic [STATE_W-1:0] state_out;
		logic               error;
	} result_t;

endpackage

// File: hdl/interleaved_rans_encode_step.sv
// Interleaved rANS encoder step: 64 lane states, frequency/cumulative table.
// Depends on irans_pkg.
//
// One command at a time: busy is high from the accepting edge until the
// result strobe. Load, read, init and a zero-frequency encode end after the
// table and lane memory read; a regular encode then does a threshold
// compare, 32 steps of the radix-2 restoring divider that forms state/freq
// and state%freq, and writeback. The result is on result in the cycle marked
// by done; it cannot be held off, and a new command may be started in that
// same cycle. Lanes read as 65536 after reset. Configuration writes take
// effect at once; the user must make them while busy is low (not enforced).
module interleaved_rans_encode_step (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  irans_pkg::item_t               item,
	output logic                           busy,
	input  logic                           cfg_we,
	input  irans_pkg::cfg_idx_t            cfg_index,
	input  logic [irans_pkg::LB_W-1:0]     cfg_data,
	output logic                           done,
	output irans_pkg::result_t             result
);

	irans_pkg::fsm_t state_q, state_d;

	logic [irans_pkg::FREQ_W+irans_pkg::CUM_W-1:0] tab_mem [irans_pkg::ALPHABET];
	logic [irans_pkg::STATE_W-1:0] lane_mem [irans_pkg::LANES];
	logic [irans_pkg::LANES-1:0]   lane_vld_q;

	logic [irans_pkg::FREQ_W+irans_pkg::CUM_W-1:0] tab_rd_q;
	logic [irans_pkg::STATE_W-1:0] lane_rd_q;

	irans_pkg::item_t              item_q;
	logic [irans_pkg::PB_W-1:0]    pb_q;
	logic [irans_pkg::LB_W-1:0]    lb_q;
	logic [irans_pkg::STATE_W-1:0] st_q;
	logic [irans_pkg::FREQ_W-1:0]  f_q;
	logic [irans_pkg::CUM_W-1:0]   c_q;
	logic [irans_pkg::LB_W+irans_pkg::FREQ_W-1:0] prod_q;
	logic [irans_pkg::STATE_W-1:0] dvd_q;
	logic [irans_pkg::FREQ_W-1:0]  rem_q;
	logic [irans_pkg::CNT_W-1:0]   cnt_q;
	logic                          wv_q;
	logic [irans_pkg::WORD_W-1:0]  word_q;
	logic                          done_q;
	irans_pkg::result_t            res_q;

	logic                          accept;
	logic                          is_load;
	logic [irans_pkg::FREQ_W-1:0]  f_rd;
	logic [irans_pkg::CUM_W-1:0]   c_rd;
	logic [irans_pkg::STATE_W-1:0] lane_val;
	logic [irans_pkg::LB_W-1:0]    bound;
	logic                          emit;
	logic [irans_pkg::FREQ_W:0]    rem_sh;
	logic                          rem_ge;
	logic [irans_pkg::FREQ_W:0]    rem_sub;
	logic [irans_pkg::STATE_W-1:0] new_state;
	logic                          lane_we;
	logic [irans_pkg::STATE_W-1:0] lane_wdata;
	logic                          fin;
	irans_pkg::result_t            res_d;

	assign accept  = start && !busy;
	assign is_load = item.cmd == irans_pkg::CMD_LOAD;
	assign f_rd    = tab_rd_q[irans_pkg::FREQ_W+irans_pkg::CUM_W-1:irans_pkg::CUM_W];
	assign c_rd    = tab_rd_q[irans_pkg::CUM_W-1:0];
	assign lane_val = lane_vld_q[item_q.lane] ? lane_rd_q : irans_pkg::LANE_RESET;
	assign bound   = lb_q >> pb_q;
	assign emit    = {{irans_pkg::LB_W+irans_pkg::FREQ_W-irans_pkg::WORD_W{1'b0}},
	                  st_q[irans_pkg::STATE_W-1:irans_pkg::WORD_W]} >= prod_q;
	assign rem_sh  = {rem_q, dvd_q[irans_pkg::STATE_W-1]};
	assign rem_ge  = rem_sh >= {1'b0, f_q};
	assign rem_sub = rem_sh - {1'b0, f_q};
	assign new_state = (dvd_q << pb_q)
	                 + {{irans_pkg::STATE_W-irans_pkg::CUM_W{1'b0}}, c_q}
	                 + {{irans_pkg::STATE_W-irans_pkg::FREQ_W{1'b0}}, rem_q};

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			irans_pkg::S_IDLE: begin
				if (start) state_d = irans_pkg::S_READ;
			end
			irans_pkg::S_READ: begin
				if (item_q.cmd == irans_pkg::CMD_ENCODE && f_rd != '0)
					state_d = irans_pkg::S_CMP;
				else
					state_d = irans_pkg::S_IDLE;
			end
			irans_pkg::S_CMP:  state_d = irans_pkg::S_DIV;
			irans_pkg::S_DIV: begin
				if (cnt_q == irans_pkg::CNT_W'(irans_pkg::STATE_W - 1))
					state_d = irans_pkg::S_DONE;
			end
			irans_pkg::S_DONE: state_d = irans_pkg::S_IDLE;
			default:           state_d = irans_pkg::S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		busy       = 1'b1;
		lane_we    = 1'b0;
		lane_wdata = new_state;
		fin        = 1'b0;
		res_d      = '0;
		case (state_q)
			irans_pkg::S_IDLE: busy = 1'b0;
			irans_pkg::S_READ: begin
				fin = 1'b1;
				case (item_q.cmd)
					irans_pkg::CMD_READ: res_d.state_out = lane_val;
					irans_pkg::CMD_INIT: begin
						lane_we    = 1'b1;
						lane_wdata = {{irans_pkg::STATE_W-irans_pkg::LB_W{1'b0}}, lb_q};
						res_d.state_out = lane_wdata;
					end
					irans_pkg::CMD_ENCODE: begin
						if (f_rd == '0) begin
							res_d.state_out = lane_val;
							res_d.error     = 1'b1;
						end else begin
							fin = 1'b0;
						end
					end
					default: res_d = '0;
				endcase
			end
			irans_pkg::S_DONE: begin
				lane_we          = 1'b1;
				fin              = 1'b1;
				res_d.word_valid = wv_q;
				res_d.word_out   = word_q;
				res_d.state_out  = new_state;
			end
			default: busy = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= irans_pkg::S_IDLE;
			pb_q       <= irans_pkg::PB_RESET;
			lb_q       <= irans_pkg::LB_RESET;
			lane_vld_q <= '0;
			done_q     <= 1'b0;
			cnt_q      <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
			if (cfg_we) begin
				case (cfg_index)
					irans_pkg::CFG_PROB_BITS:   pb_q <= cfg_data[irans_pkg::PB_W-1:0];
					irans_pkg::CFG_LOWER_BOUND: lb_q <= cfg_data;
					default:                    lb_q <= lb_q;
				endcase
			end
			if (lane_we) lane_vld_q[item_q.lane] <= 1'b1;
			if (state_q == irans_pkg::S_CMP)
				cnt_q <= '0;
			else if (state_q == irans_pkg::S_DIV)
				cnt_q <= cnt_q + 1'b1;
		end
	end

	// memories
	always_ff @(posedge clk) begin
		if (accept && is_load)
			tab_mem[item.symbol] <= {item.freq_in, item.cumul_in};
		tab_rd_q  <= tab_mem[item.symbol];
		lane_rd_q <= lane_mem[item.lane];
		if (lane_we) lane_mem[item_q.lane] <= lane_wdata;
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) item_q <= item;
		if (fin) res_q <= res_d;
		case (state_q)
			irans_pkg::S_READ: begin
				st_q   <= lane_val;
				f_q    <= f_rd;
				c_q    <= c_rd;
				prod_q <= bound * f_rd;
			end
			irans_pkg::S_CMP: begin
				wv_q   <= emit;
				word_q <= emit ? st_q[irans_pkg::WORD_W-1:0] : '0;
				dvd_q  <= emit ? (st_q >> irans_pkg::WORD_W) : st_q;
				rem_q  <= '0;
			end
			irans_pkg::S_DIV: begin
				rem_q <= rem_ge ? rem_sub[irans_pkg::FREQ_W-1:0]
				                : rem_sh[irans_pkg::FREQ_W-1:0];
				dvd_q <= {dvd_q[irans_pkg::STATE_W-2:0], rem_ge};
			end
			default: wv_q <= wv_q;
		endcase
	end

	assign done   = done_q;
	assign result = res_q;

endmodule
